// File: src/tmf_pkg.sv
// tmf_pkg: shared types and constants of the trimmed mean filter
// used by trimmed_mean_filter and tmf_checker; depends on nothing else
package tmf_pkg;

  // default depth of the sample window
  localparam int unsigned MAX_WINDOW_DEFAULT = 16;

  // fixed field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WIN_LEN_W = 5;
  localparam int unsigned TRIM_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_TRIM          = 1'b1
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_KEYW,
    S_SCAN,
    S_ACC,
    S_DIVP,
    S_DIV,
    S_FIN
  } state_e;

endpackage

// File: src/tmf_ram.sv
// tmf_ram: generic single-write, single-read ram with registered read data
// used by trimmed_mean_filter; depends on nothing else
module tmf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/trimmed_mean_filter.sv
// One ram read port and one comparator rank every entry of the effective window
// against every other, then a bit-serial divide runs over the SUM_W bits of the
// sum, SUM_W = 16 + clog2(MaxWindow+1). No new sample is taken until the mean of
// the last one has been loaded into the output register.
// Reset (async, active low) clears the window to zeros through per-entry valid
// bits, the write position, and sets window_length to 16 and trim to 0.
// trimmed_mean_filter: top level, sequencer, rank/sum datapath and divider
// depends on tmf_pkg and tmf_ram
module trimmed_mean_filter #(
  parameter int unsigned MaxWindow = tmf_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               sample_valid_i,
  output logic                               sample_stall_o,
  input  logic signed [tmf_pkg::SAMPLE_W-1:0] sample_i,
  // mean channel
  output logic                               mean_valid_o,
  input  logic                               mean_stall_i,
  output logic signed [tmf_pkg::SAMPLE_W-1:0] mean_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tmf_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  localparam int unsigned SampleW = tmf_pkg::SAMPLE_W;
  localparam int unsigned PosW    = $clog2(MaxWindow);
  localparam int unsigned LenW    = $clog2(MaxWindow + 1);
  localparam int unsigned SumW    = SampleW + LenW;
  localparam int unsigned CntW    = $clog2(SumW + 1);
  localparam int unsigned CmpW    = (LenW > tmf_pkg::WIN_LEN_W) ? LenW : tmf_pkg::WIN_LEN_W;

  tmf_pkg::state_e state_q, state_d;

  // configuration registers
  logic [tmf_pkg::WIN_LEN_W-1:0] win_len_q;
  logic [tmf_pkg::TRIM_W-1:0]    trim_q;

  // window bookkeeping
  logic [PosW-1:0]      pos_q;
  logic [MaxWindow-1:0] vld_q;
  logic                 rd_vld_q;

  // per-item registers
  logic [LenW-1:0]            len_q, t_q, hi_q, count_q, rank_q;
  logic [PosW-1:0]            i_q, j_q;
  logic signed [SampleW-1:0]  key_q;
  logic signed [SumW-1:0]     sum_q;
  logic                       neg_q;
  logic [SumW-1:0]            quo_q;
  logic [LenW-1:0]            rem_q;
  logic [CntW-1:0]            div_cnt_q;

  // output register
  logic                       out_valid_q;
  logic signed [SampleW-1:0]  mean_q;

  // combinational signals
  logic                      accept;
  logic                      out_free;
  logic                      out_load;
  logic [CmpW-1:0]           wl_ext;
  logic [LenW-1:0]           len_c, half_c, t_c;
  logic [PosW-1:0]           wpos_c, pnext_c;
  logic [LenW-1:0]           pinc_c;
  logic [PosW-1:0]           raddr;
  logic [SampleW-1:0]        ram_rdata;
  logic signed [SampleW-1:0] rd_val;
  logic                      below;
  logic                      scan_last, key_last;
  logic                      in_range;
  logic [SumW-1:0]           mag_c;
  logic [LenW:0]             rem_sh;
  logic                      rem_ge;
  logic [SumW-1:0]           quo_fin;

  assign accept   = sample_valid_i && (state_q == tmf_pkg::S_IDLE);
  assign out_free = !out_valid_q || !mean_stall_i;

  // effective length, clamped trim and write slot from the current configuration
  always_comb begin
    wl_ext = CmpW'(win_len_q);
    if (wl_ext == '0) begin
      len_c = LenW'(1);
    end else if (wl_ext > CmpW'(MaxWindow)) begin
      len_c = LenW'(MaxWindow);
    end else begin
      len_c = wl_ext[LenW-1:0];
    end
    half_c = (len_c - LenW'(1)) >> 1;
    if (CmpW'(trim_q) > CmpW'(half_c)) begin
      t_c = half_c;
    end else begin
      t_c = LenW'(trim_q);
    end
    if (LenW'(pos_q) >= len_c) begin
      wpos_c = '0;
    end else begin
      wpos_c = pos_q;
    end
    pinc_c = LenW'(wpos_c) + LenW'(1);
    if (pinc_c >= len_c) begin
      pnext_c = '0;
    end else begin
      pnext_c = pinc_c[PosW-1:0];
    end
  end

  // window storage
  tmf_ram #(
    .Width(SampleW),
    .Depth(MaxWindow)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(wpos_c),
    .wdata_i(sample_i),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // never-written entries read as zero
  assign rd_val = rd_vld_q ? $signed(ram_rdata) : '0;

  // shared comparator: entry below the key, ties broken by slot order
  assign below     = (rd_val < key_q) || ((rd_val == key_q) && (j_q < i_q));
  assign scan_last = (LenW'(j_q) == (len_q - LenW'(1)));
  assign key_last  = (LenW'(i_q) == (len_q - LenW'(1)));
  assign in_range  = (rank_q >= t_q) && (rank_q < hi_q);

  // divider step on magnitudes
  assign mag_c   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign rem_sh  = {rem_q, quo_q[SumW-1]};
  assign rem_ge  = rem_sh >= {1'b0, count_q};
  assign quo_fin = neg_q ? (~quo_q + SumW'(1)) : quo_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmf_pkg::S_IDLE: if (accept) state_d = tmf_pkg::S_KEY;
      tmf_pkg::S_KEY:  state_d = tmf_pkg::S_KEYW;
      tmf_pkg::S_KEYW: state_d = tmf_pkg::S_SCAN;
      tmf_pkg::S_SCAN: if (scan_last) state_d = tmf_pkg::S_ACC;
      tmf_pkg::S_ACC: begin
        if (key_last) state_d = tmf_pkg::S_DIVP;
        else          state_d = tmf_pkg::S_KEY;
      end
      tmf_pkg::S_DIVP: state_d = tmf_pkg::S_DIV;
      tmf_pkg::S_DIV:  if (div_cnt_q == CntW'(1)) state_d = tmf_pkg::S_FIN;
      tmf_pkg::S_FIN:  if (out_free) state_d = tmf_pkg::S_IDLE;
      default:         state_d = tmf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sample_stall_o = 1'b1;
    raddr          = '0;
    out_load       = 1'b0;
    unique case (state_q)
      tmf_pkg::S_IDLE: sample_stall_o = 1'b0;
      tmf_pkg::S_KEY:  raddr = i_q;
      tmf_pkg::S_SCAN: raddr = scan_last ? '0 : (j_q + PosW'(1));
      tmf_pkg::S_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmf_pkg::S_IDLE;
      win_len_q   <= tmf_pkg::WIN_LEN_W'(16);
      trim_q      <= '0;
      pos_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tmf_pkg::REG_WINDOW_LENGTH: win_len_q <= cfg_data_i;
          tmf_pkg::REG_TRIM:          trim_q <= cfg_data_i[tmf_pkg::TRIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        pos_q         <= pnext_c;
        vld_q[wpos_c] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!mean_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_q[raddr];
    case (state_q)
      tmf_pkg::S_IDLE: begin
        len_q   <= len_c;
        t_q     <= t_c;
        hi_q    <= len_c - t_c;
        count_q <= len_c - (t_c << 1);
        i_q     <= '0;
        sum_q   <= '0;
      end
      tmf_pkg::S_KEYW: begin
        key_q  <= rd_val;
        j_q    <= '0;
        rank_q <= '0;
      end
      tmf_pkg::S_SCAN: begin
        if (below) rank_q <= rank_q + LenW'(1);
        j_q <= j_q + PosW'(1);
      end
      tmf_pkg::S_ACC: begin
        if (in_range) begin
          sum_q <= sum_q + {{(SumW - SampleW){key_q[SampleW-1]}}, key_q};
        end
        i_q <= i_q + PosW'(1);
      end
      tmf_pkg::S_DIVP: begin
        neg_q     <= sum_q[SumW-1];
        quo_q     <= mag_c;
        rem_q     <= '0;
        div_cnt_q <= CntW'(SumW);
      end
      tmf_pkg::S_DIV: begin
        if (rem_ge) begin
          rem_q <= LenW'(rem_sh - {1'b0, count_q});
        end else begin
          rem_q <= rem_sh[LenW-1:0];
        end
        quo_q     <= {quo_q[SumW-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - CntW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      mean_q <= $signed(quo_fin[SampleW-1:0]);
    end
  end

  assign mean_valid_o = out_valid_q;
  assign mean_o       = mean_q;
  assign cfg_ready_o  = 1'b1;

endmodule

// File: src/tmf_checker.sv
// tmf_checker: port-level assertions for trimmed_mean_filter, bound to it below
// depends on the port list of trimmed_mean_filter
module tmf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         sample_valid_i,
  input logic                         sample_stall_o,
  input logic                         mean_valid_o,
  input logic                         mean_stall_i,
  input logic [tmf_pkg::SAMPLE_W-1:0] mean_o
);

  // a stalled mean holds
  a_mean_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_o && mean_stall_i |=> mean_valid_o && $stable(mean_o))
    else $error("stalled mean changed or dropped");

  // a sample request starts a busy period
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && !sample_stall_o |=> sample_stall_o)
    else $error("sample channel not stalled after request");

  // a new mean only appears out of a busy period
  a_mean_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mean_valid_o) |-> $past(sample_stall_o))
    else $error("mean appeared while idle");

endmodule

bind trimmed_mean_filter tmf_checker u_tmf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .sample_valid_i(sample_valid_i),
  .sample_stall_o(sample_stall_o),
  .mean_valid_o  (mean_valid_o),
  .mean_stall_i  (mean_stall_i),
  .mean_o        (mean_o)
);

// File: dv/trimmed_mean_filter_test.sv
`timescale 1ns / 100ps
// trimmed_mean_filter_test: self-checking bench with a scoreboard that predicts each trimmed mean
// depends on tmf_pkg and the trimmed_mean_filter rtl

// predicts the mean for every accepted sample request and checks the means that come back
class tmf_scoreboard;
  localparam int MAX_WIN = tmf_pkg::MAX_WINDOW_DEFAULT;

  int                   win_len_reg;
  int                   trim_reg;
  int                   window [MAX_WIN];
  int                   wr_pos;
  logic signed [15:0]   pending_means [$];
  int                   errors;
  int                   means_checked;

  function new();
    win_len_reg   = 16;
    trim_reg      = 0;
    wr_pos        = 0;
    errors        = 0;
    means_checked = 0;
    foreach (window[i]) window[i] = 0;
  endfunction

  // register write as the block sees it
  function void write_reg(tmf_pkg::cfg_reg_e idx, logic [tmf_pkg::CFG_DAT_W-1:0] data);
    if (idx == tmf_pkg::REG_WINDOW_LENGTH) win_len_reg = int'(data);
    else trim_reg = int'(data[tmf_pkg::TRIM_W-1:0]);
  endfunction

  // store the sample, sort a copy of the active window, average the untrimmed middle
  function void add_sample(logic signed [15:0] value);
    int len;
    int t;
    int pos;
    int sum;
    int key;
    int j;
    int sorted [MAX_WIN];
    len = (win_len_reg == 0) ? 1 : ((win_len_reg > MAX_WIN) ? MAX_WIN : win_len_reg);
    // a shrunk window can leave the write slot past its end
    pos = (wr_pos >= len) ? 0 : wr_pos;
    window[pos] = value;
    pos++;
    wr_pos = (pos >= len) ? 0 : pos;
    for (int i = 0; i < len; i++) sorted[i] = window[i];
    for (int i = 1; i < len; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    // at least one entry always survives the trim
    t = (trim_reg > (len - 1) / 2) ? (len - 1) / 2 : trim_reg;
    sum = 0;
    for (int i = t; i < len - t; i++) sum += sorted[i];
    pending_means.push_back(16'(sum / (len - 2 * t)));
  endfunction

  // compare one returned mean with the oldest prediction
  function void check_mean(logic signed [15:0] actual);
    logic signed [15:0] expected;
    means_checked++;
    if (pending_means.size() == 0) begin
      $error("mean: no result expected, got %0d", actual);
      errors++;
    end else begin
      expected = pending_means.pop_front();
      if (expected !== actual) begin
        $error("mean: expected %0d, got %0d", expected, actual);
        errors++;
      end
    end
  endfunction
endclass

module trimmed_mean_filter_test;

  localparam int TOTAL_ITEMS  = 850;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 340;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                sample_valid_i = 1'b0;
  logic                                sample_stall_o;
  logic signed [tmf_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                                mean_valid_o;
  logic                                mean_stall_i = 1'b0;
  logic signed [tmf_pkg::SAMPLE_W-1:0] mean_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [tmf_pkg::CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [tmf_pkg::CFG_DAT_W-1:0]       cfg_data_i = '0;

  tmf_scoreboard sb = new();
  bit  calm = 1'b0;
  int  samples_sent = 0;
  int  cfg_writes = 0;
  int  phases = 0;
  int  cycle_count = 0;

  trimmed_mean_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_i      (sample_i),
    .mean_valid_o  (mean_valid_o),
    .mean_stall_i  (mean_stall_i),
    .mean_o        (mean_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** trimmed_mean_filter: FAILED **");
      $finish;
    end
  end

  // mean receiver: check accepted results, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && mean_valid_o && !mean_stall_i) sb.check_mean(mean_o);
    mean_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // sample request with random idle cycles ahead of it; valid stays up after acceptance
  task automatic send_sample(input logic signed [tmf_pkg::SAMPLE_W-1:0] value);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= value;
    do begin
      @(posedge clk_i);
    end while (sample_stall_o);
    sb.add_sample(value);
    samples_sent++;
  endtask

  // stop sending and wait until every predicted mean has come back
  task automatic drain_means();
    sample_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.pending_means.size() != 0);
  endtask

  // write window length then trim, back to back
  task automatic write_config(input logic [tmf_pkg::CFG_DAT_W-1:0] len_data,
                              input logic [tmf_pkg::CFG_DAT_W-1:0] trim_data);
    tmf_pkg::cfg_reg_e idx;
    logic [tmf_pkg::CFG_DAT_W-1:0] data;
    for (int k = 0; k < 2; k++) begin
      idx  = (k == 0) ? tmf_pkg::REG_WINDOW_LENGTH : tmf_pkg::REG_TRIM;
      data = (k == 0) ? len_data : trim_data;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do begin
        @(posedge clk_i);
      end while (!cfg_ready_o);
      sb.write_reg(idx, data);
      cfg_writes++;
    end
    cfg_valid_i <= 1'b0;
    phases++;
  endtask

  // mostly short windows to keep the sort fast, some full and out of range
  function automatic logic [tmf_pkg::CFG_DAT_W-1:0] pick_length();
    case ($urandom_range(19)) inside
      0:       return '0;
      1:       return tmf_pkg::CFG_DAT_W'($urandom_range(31, 17));
      [2:3]:   return tmf_pkg::CFG_DAT_W'(16);
      [4:7]:   return tmf_pkg::CFG_DAT_W'($urandom_range(15, 9));
      default: return tmf_pkg::CFG_DAT_W'($urandom_range(8, 1));
    endcase
  endfunction

  // extremes, clustered small values for ties, and full range
  function automatic logic signed [tmf_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9)) inside
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      [2:3]:   return tmf_pkg::SAMPLE_W'($signed($urandom_range(16)) - 8);
      default: return tmf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full window of zeros with extremes entering
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    // three-entry median
    drain_means();
    write_config(5'd3, 5'd1);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    // zero length acts as one, trim clamps to nothing
    drain_means();
    write_config(5'd0, 5'd7);
    send_sample(16'sh8000);
    send_sample(16'sd5);
    // oversized length saturates to full window, trim 7 leaves the middle two
    drain_means();
    write_config(5'd31, 5'd7);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd100);
    // shrink below write slot; negative mean truncates toward zero
    drain_means();
    write_config(5'd2, 5'd3);
    send_sample(-16'sd1);
    send_sample(-16'sd2);
    send_sample(-16'sd3);
    // grow again, stale entries reused as they stand
    drain_means();
    write_config(5'd16, 5'd0);
    for (int i = 0; i < 4; i++) send_sample(16'sh8000);
    drain_means();
    write_config(5'd5, 5'd2);
    send_sample(16'sd7);
    send_sample(-16'sd7);
    send_sample(16'sd0);

    // random phases, one of them with no idling on either side
    while (samples_sent < TOTAL_ITEMS) begin
      drain_means();
      write_config(pick_length(), tmf_pkg::CFG_DAT_W'($urandom_range(31)));
      calm = (phases == 9);
      n = $urandom_range(50, 10);
      for (int i = 0; i < n; i++) begin
        send_sample(pick_sample());
        if ($urandom_range(199) == 0) drain_means();
      end
    end
    calm = 1'b0;

    drain_means();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d samples over %0d register settings, checked %0d means",
             samples_sent, phases, sb.means_checked);
    $display("window lengths 0..31 and trims 0..7 with random stalls on both channels");
    if (sb.errors == 0) begin
      $display("** trimmed_mean_filter: PASSED **");
    end else begin
      $display("** trimmed_mean_filter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
src/tmf_pkg.sv
src/tmf_ram.sv
src/trimmed_mean_filter.sv
src/tmf_checker.sv
dv/trimmed_mean_filter_test.sv
